// ----- rtl/modulo_hash_table_engine_unit_macros.svh -----
// Assertion macros for the hash table engine checker.
// No dependencies.
`ifndef MODULO_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
`define MODULO_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
// implication checked every clock, off during reset
`define MHT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MHT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/mht_pkg.sv -----
// Shared types and constants for the modulo hash table engine.
// No dependencies.
package mht_pkg;
  localparam int unsigned MaxBuckets    = 8;
  localparam int unsigned WaysPerBucket = 4;
  localparam logic [3:0]  ResetBuckets  = 4'd7;
  localparam int unsigned KeyW          = 31;
  localparam int unsigned ValW          = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0, REQ_FIND = 2'd1, REQ_DELETE = 2'd2, REQ_FIND_ALT = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]      bucket_index;
    logic [2:0]      status;
    logic [ValW-1:0] found_value;
  } rsp_t;

  typedef enum logic [1:0] {FE_IDLE, FE_DIV, FE_PUSH} fe_state_e;
  typedef enum logic [1:0] {BE_IDLE, BE_SCAN, BE_DONE} be_state_e;
endpackage

// ----- rtl/modulo_hash_table_engine_unit.sv -----
// Top level of the modulo hash table engine: APB register, front, queue, back.
// Depends on mht_pkg, mht_front, mht_fifo, mht_back.
//
// channel   | handshake         | payload
// ----------+-------------------+------------------------
// request   | start / busy      | req_i (mht_pkg::req_t)
// result    | done_o strobe     | rsp_o (mht_pkg::rsp_t)
// config    | APB psel/penable  | bucket_count at 0x0
//
// An accepted request keeps busy high through the bit-serial modulo and the push
// into the queue, which waits while the queue is full. The back end then picks up
// the request, scans the bucket's ways and writes back; done_o is registered from
// the write-back state. The back end drains each entry before the front end can
// push the next, so the queue never fills and the front end does not stall.
// Reset empties the table at once (valid flags). done_o cannot be stalled.
module modulo_hash_table_engine_unit #(
  parameter int unsigned MaxBuckets    = mht_pkg::MaxBuckets,
  parameter int unsigned WaysPerBucket = mht_pkg::WaysPerBucket
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mht_pkg::req_t req_i,
  output logic          done_o,
  output mht_pkg::rsp_t rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  localparam int unsigned BW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned NW = $clog2(MaxBuckets + 1);
  localparam int unsigned QW = $bits(mht_pkg::req_t) + BW;

  logic [3:0]    bcount_q;
  logic [NW-1:0] nbuck;
  logic          push, pop, full, empty;
  mht_pkg::req_t f_req, b_req;
  logic [BW-1:0] f_bucket, b_bucket;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bcount_q <= mht_pkg::ResetBuckets;
    else if (psel && penable && pwrite && paddr == 2'd0) bcount_q <= pwdata[3:0];
  end
  assign prdata = (paddr == 2'd0) ? {28'd0, bcount_q} : 32'd0;

  always_comb begin
    if (bcount_q == 4'd0) nbuck = NW'(1);
    else if ({28'd0, bcount_q} > 32'(MaxBuckets)) nbuck = NW'(MaxBuckets);
    else nbuck = NW'(bcount_q);
  end

  mht_front #(.MaxBuckets(MaxBuckets)) u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .nbuck_i(nbuck), .busy_o(busy),
    .push_o(push), .req_o(f_req), .bucket_o(f_bucket), .full_i(full)
  );

  mht_fifo #(.W(QW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i({f_req, f_bucket}), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o({b_req, b_bucket})
  );

  mht_back #(.MaxBuckets(MaxBuckets), .WaysPerBucket(WaysPerBucket)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .req_i(b_req), .bucket_i(b_bucket),
    .pop_o(pop), .done_o, .rsp_o
  );
endmodule

// ----- rtl/mht_front.sv -----
// Front end: takes a request, reduces key modulo bucket count bit-serially.
// Depends on mht_pkg.
module mht_front #(
  parameter int unsigned MaxBuckets = mht_pkg::MaxBuckets,
  localparam int unsigned BW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1,
  localparam int unsigned NW = $clog2(MaxBuckets + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mht_pkg::req_t  req_i,
  input  logic [NW-1:0]  nbuck_i,
  output logic           busy_o,
  output logic           push_o,
  output mht_pkg::req_t  req_o,
  output logic [BW-1:0]  bucket_o,
  input  logic           full_i
);
  localparam int unsigned KW = mht_pkg::KeyW;
  localparam int unsigned CW = $clog2(KW + 1);

  mht_pkg::fe_state_e state_q, state_d;
  mht_pkg::req_t      req_q;
  logic [KW-1:0]      sh_q;
  logic [NW-1:0]      rem_q, rem_d;
  logic [NW-1:0]      div_q;
  logic [CW-1:0]      cnt_q;
  logic [NW:0]        trial;

  assign trial = {rem_q, sh_q[KW-1]};

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    push_o  = 1'b0;
    case (state_q)
      mht_pkg::FE_IDLE: if (start_i) state_d = mht_pkg::FE_DIV;
      mht_pkg::FE_DIV: begin
        rem_d = (trial >= {1'b0, div_q}) ? NW'(trial - {1'b0, div_q}) : NW'(trial);
        if (cnt_q == CW'(1)) state_d = mht_pkg::FE_PUSH;
      end
      mht_pkg::FE_PUSH: if (!full_i) begin
        push_o  = 1'b1;
        state_d = mht_pkg::FE_IDLE;
      end
      default: state_d = mht_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mht_pkg::FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mht_pkg::FE_IDLE) cnt_q <= CW'(KW);
      else if (state_q == mht_pkg::FE_DIV) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mht_pkg::FE_IDLE && start_i) begin
      req_q <= req_i;
      sh_q  <= req_i.key;
      rem_q <= '0;
      div_q <= nbuck_i;
    end else if (state_q == mht_pkg::FE_DIV) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[KW-2:0], 1'b0};
    end
  end

  assign busy_o   = (state_q != mht_pkg::FE_IDLE);
  assign req_o    = req_q;
  assign bucket_o = BW'(rem_q);
endmodule

// ----- rtl/mht_fifo.sv -----
// Two-entry queue between front and back end.
// No dependencies.
module mht_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];
endmodule

// ----- rtl/mht_back.sv -----
// Back end: scans a bucket's ways in the slot memory, then writes back.
// Depends on mht_pkg.
module mht_back #(
  parameter int unsigned MaxBuckets    = mht_pkg::MaxBuckets,
  parameter int unsigned WaysPerBucket = mht_pkg::WaysPerBucket,
  localparam int unsigned BW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1,
  localparam int unsigned WW = (WaysPerBucket > 1) ? $clog2(WaysPerBucket) : 1,
  localparam int unsigned Slots = MaxBuckets * WaysPerBucket,
  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  mht_pkg::req_t req_i,
  input  logic [BW-1:0] bucket_i,
  output logic          pop_o,
  output logic          done_o,
  output mht_pkg::rsp_t rsp_o
);
  localparam int unsigned KW = mht_pkg::KeyW;
  localparam int unsigned VW = mht_pkg::ValW;

  mht_pkg::be_state_e state_q, state_d;
  logic [Slots-1:0]   valid_q;
  logic [KW-1:0]      key_mem [Slots];
  logic [VW-1:0]      val_mem [Slots];
  logic [KW-1:0]      rkey_q;
  logic [VW-1:0]      rval_q;
  logic [WW:0]        way_q;      // way whose data sits in rkey_q/rval_q, plus 1
  logic [WW-1:0]      hit_w_q, free_w_q;
  logic               hit_q, free_q;
  logic [SW-1:0]      rd_addr, base;
  logic [WW-1:0]      cur_w;
  logic               cur_ok, cur_hit;
  mht_pkg::rsp_t      rsp_q;
  logic               done_q;

  assign base    = SW'(bucket_i) * SW'(WaysPerBucket);
  assign cur_w   = WW'(way_q - (WW+1)'(1));
  assign cur_ok  = (way_q != '0);
  assign cur_hit = cur_ok && valid_q[base + SW'(cur_w)] && (rkey_q == req_i.key);
  assign rd_addr = base + SW'(way_q);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      mht_pkg::BE_IDLE: if (!empty_i) state_d = mht_pkg::BE_SCAN;
      mht_pkg::BE_SCAN: if (way_q == (WW+1)'(WaysPerBucket)) state_d = mht_pkg::BE_DONE;
      mht_pkg::BE_DONE: begin
        pop_o   = 1'b1;
        state_d = mht_pkg::BE_IDLE;
      end
      default: state_d = mht_pkg::BE_IDLE;
    endcase
  end

  // synchronous memory read, one way per cycle
  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[rd_addr];
    rval_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mht_pkg::BE_IDLE;
      valid_q <= '0;
      way_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        mht_pkg::BE_IDLE: begin
          way_q  <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          if (!empty_i) way_q <= (WW+1)'(1);
        end
        mht_pkg::BE_SCAN: begin
          if (cur_ok) begin
            if (cur_hit && !hit_q) begin
              hit_q   <= 1'b1;
              hit_w_q <= cur_w;
              if (req_i.req_type == mht_pkg::REQ_FIND ||
                  req_i.req_type == mht_pkg::REQ_FIND_ALT)
                rsp_q.found_value <= rval_q;
            end
            if (!valid_q[base + SW'(cur_w)] && !free_q) begin
              free_q   <= 1'b1;
              free_w_q <= cur_w;
            end
          end
          if (way_q != (WW+1)'(WaysPerBucket)) way_q <= way_q + (WW+1)'(1);
          else way_q <= '0;
        end
        mht_pkg::BE_DONE: begin
          done_q <= 1'b1;
          rsp_q.bucket_index <= 3'(bucket_i);
          case (req_i.req_type)
            mht_pkg::REQ_INSERT: begin
              rsp_q.found_value <= '0;
              if (hit_q) rsp_q.status <= mht_pkg::ST_UPDATED;
              else if (free_q) begin
                rsp_q.status <= mht_pkg::ST_INSERTED;
                valid_q[base + SW'(free_w_q)] <= 1'b1;
              end else rsp_q.status <= mht_pkg::ST_FULL;
            end
            mht_pkg::REQ_DELETE: begin
              rsp_q.found_value <= '0;
              if (hit_q) begin
                rsp_q.status <= mht_pkg::ST_DELETED;
                valid_q[base + SW'(hit_w_q)] <= 1'b0;
              end else rsp_q.status <= mht_pkg::ST_NOT_FOUND;
            end
            default: begin
              if (hit_q) rsp_q.status <= mht_pkg::ST_FOUND;
              else begin
                rsp_q.status      <= mht_pkg::ST_NOT_FOUND;
                rsp_q.found_value <= '0;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // data write-back on insert
  always_ff @(posedge clk_i) begin
    if (state_q == mht_pkg::BE_DONE && req_i.req_type == mht_pkg::REQ_INSERT) begin
      if (hit_q) val_mem[base + SW'(hit_w_q)] <= req_i.value;
      else if (free_q) begin
        key_mem[base + SW'(free_w_q)] <= req_i.key;
        val_mem[base + SW'(free_w_q)] <= req_i.value;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule

// ----- rtl/mht_checker.sv -----
// Port-level checker for the hash table engine, bound to the top level.
// Depends on mht_pkg and modulo_hash_table_engine_unit_macros.svh.
`include "modulo_hash_table_engine_unit_macros.svh"
module mht_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input mht_pkg::rsp_t rsp_o,
  input logic          pready
);
  `MHT_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready, "pready low")
  `MHT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "no busy after accept")
  `MHT_ASSERT_IMP(a_status, clk_i, rst_ni, done_o, rsp_o.status <= mht_pkg::ST_FULL,
                  "bad status")
  `MHT_ASSERT_IMP(a_value0, clk_i, rst_ni, done_o && rsp_o.status != mht_pkg::ST_FOUND,
                  rsp_o.found_value == '0, "nonzero value")
  `MHT_ASSERT_NXT(a_strobe, clk_i, rst_ni, done_o, !done_o, "double strobe")
endmodule

bind modulo_hash_table_engine_unit mht_checker u_mht_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o, .pready
);
